>>> src/imm_pkg.sv
`timescale 1ns / 1ps

package imm_pkg;

  // fixed field widths
  localparam int DATA_W      = 32;
  localparam int IDX_W       = 3;
  localparam int SIZE_W      = 4;
  localparam int OP_W        = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int MAX_DIM_DEF = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
  localparam logic [OP_W-1:0] OP_COMPUTE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic wr_a;
    logic wr_b;
    logic rd_en;
    logic first;
    logic last;
    logic final_elem;
    logic load_err;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
    logic res_done;
  } stat_t;

endpackage

>>> src/imm_ctrl.sv
`timescale 1ns / 1ps

module imm_ctrl #(
  parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [imm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [imm_pkg::SIZE_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [imm_pkg::OP_W-1:0]            in_operation,
  input  logic [imm_pkg::IDX_W-1:0]           in_row_index,
  input  logic [imm_pkg::IDX_W-1:0]           in_col_index,
  input  imm_pkg::stat_t                      status,
  output imm_pkg::cmd_t                       cmd,
  output logic [$clog2(MAX_DIM)-1:0]          rd_i,
  output logic [$clog2(MAX_DIM)-1:0]          rd_j,
  output logic [$clog2(MAX_DIM)-1:0]          rd_k
);
  import imm_pkg::*;

  localparam int IW = $clog2(MAX_DIM);
  localparam int SW = $clog2(MAX_DIM + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ISSUE = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_ERR   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [IW-1:0]     i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [SIZE_W-1:0] rows_a_r, cols_a_r, rows_b_r, cols_b_r;
  logic [SW-1:0]     ra_used, ca_used, rb_used, cb_used;
  logic              in_xfer, in_range, k_last, i_last, j_last;

  // clamp a size register to 1..MAX_DIM
  function automatic logic [SW-1:0] used_size(input logic [SIZE_W-1:0] v);
    logic [SW-1:0] res;
    if (v == '0) begin
      res = SW'(1);
    end else if (int'(v) > MAX_DIM) begin
      res = SW'(MAX_DIM);
    end else begin
      res = SW'(v);
    end
    return res;
  endfunction

  assign ra_used = used_size(rows_a_r);
  assign ca_used = used_size(cols_a_r);
  assign rb_used = used_size(rows_b_r);
  assign cb_used = used_size(cols_b_r);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign in_range  = (int'(in_row_index) < MAX_DIM) && (int'(in_col_index) < MAX_DIM);

  // loop end flags
  assign k_last = ((SW'(k_r) + SW'(1)) == ca_used);
  assign i_last = ((SW'(i_r) + SW'(1)) == ra_used);
  assign j_last = ((SW'(j_r) + SW'(1)) == cb_used);

  assign rd_i = i_r;
  assign rd_j = j_r;
  assign rd_k = k_r;

  // size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= SIZE_W'(1);
      cols_a_r <= SIZE_W'(1);
      rows_b_r <= SIZE_W'(1);
      cols_b_r <= SIZE_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROWS_A: rows_a_r <= cfg_data;
        REG_COLS_A: cols_a_r <= cfg_data;
        REG_ROWS_B: rows_b_r <= cfg_data;
        REG_COLS_B: cols_b_r <= cfg_data;
        default:    rows_a_r <= rows_a_r;
      endcase
    end
  end

  // sequencer: walks i, j over results and k over the shared dimension
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_operation)
            OP_WRITE_A: cmd.wr_a = in_range;
            OP_WRITE_B: cmd.wr_b = in_range;
            OP_COMPUTE: begin
              i_nxt     = '0;
              j_nxt     = '0;
              k_nxt     = '0;
              state_nxt = (ca_used != rb_used) ? S_ERR : S_ISSUE;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ISSUE: begin
        // a new element starts only when the output register will be free
        if ((k_r != '0) || status.out_free) begin
          cmd.rd_en      = 1'b1;
          cmd.first      = (k_r == '0);
          cmd.last       = k_last;
          cmd.final_elem = k_last && i_last && j_last;
          if (k_last) begin
            state_nxt = S_DRAIN;
          end else begin
            k_nxt = k_r + IW'(1);
          end
        end
      end
      S_DRAIN: begin
        if (status.res_done) begin
          k_nxt = '0;
          if (j_last) begin
            j_nxt = '0;
            if (i_last) begin
              state_nxt = S_IDLE;
            end else begin
              i_nxt     = i_r + IW'(1);
              state_nxt = S_ISSUE;
            end
          end else begin
            j_nxt     = j_r + IW'(1);
            state_nxt = S_ISSUE;
          end
        end
      end
      S_ERR: begin
        if (status.out_free) begin
          cmd.load_err = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  // a finished sum only arrives while the sequencer waits for it
  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    status.res_done |-> (state_r == S_DRAIN))
    else $error("result finished outside drain state");

  // inner index stays inside the shared dimension
  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ISSUE) |-> (SW'(k_r) < ca_used))
    else $error("inner index out of range");

  // error path only taken on a real size mismatch
  a_err_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ERR) |-> (ca_used != rb_used))
    else $error("size error without mismatch");

endmodule

>>> src/imm_dpath.sv
`timescale 1ns / 1ps

module imm_dpath #(
  parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  imm_pkg::cmd_t                       cmd,
  output imm_pkg::stat_t                      status,
  input  logic [$clog2(MAX_DIM)-1:0]          rd_i,
  input  logic [$clog2(MAX_DIM)-1:0]          rd_j,
  input  logic [$clog2(MAX_DIM)-1:0]          rd_k,
  input  logic [imm_pkg::IDX_W-1:0]           in_row_index,
  input  logic [imm_pkg::IDX_W-1:0]           in_col_index,
  input  logic signed [imm_pkg::DATA_W-1:0]   in_element_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [imm_pkg::IDX_W-1:0]           out_row,
  output logic [imm_pkg::IDX_W-1:0]           out_col,
  output logic signed [imm_pkg::DATA_W-1:0]   out_product_value,
  output logic                                out_last_result,
  output logic                                out_size_error
);
  import imm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] DIM_A = AW'(MAX_DIM);

  typedef struct packed {
    logic             first;
    logic             last;
    logic             final_elem;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

  logic [DATA_W-1:0] mem_a [DEPTH];
  logic [DATA_W-1:0] mem_b [DEPTH];

  logic [AW-1:0]     wr_addr, addr_a, addr_b;
  logic [DATA_W-1:0] rd_a_r, rd_b_r, prod_r, acc_r, sum;
  logic              v1_r, v2_r, out_valid_r, res_done;
  tag_t              tag1_r, tag2_r;
  logic [IDX_W-1:0]  out_row_r, out_col_r;
  logic [DATA_W-1:0] out_value_r;
  logic              out_last_r, out_err_r;

  // element addresses, row-major
  assign wr_addr = AW'(in_row_index) * DIM_A + AW'(in_col_index);
  assign addr_a  = AW'(rd_i) * DIM_A + AW'(rd_k);
  assign addr_b  = AW'(rd_k) * DIM_A + AW'(rd_j);

  // operand stores, one write and one registered read each
  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      mem_a[wr_addr] <= in_element_value;
    end
    if (cmd.wr_b) begin
      mem_b[wr_addr] <= in_element_value;
    end
    if (cmd.rd_en) begin
      rd_a_r <= mem_a[addr_a];
      rd_b_r <= mem_b[addr_b];
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
    end
  end

  // multiply stage, low 32 bits of the product
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      tag1_r.first      <= cmd.first;
      tag1_r.last       <= cmd.last;
      tag1_r.final_elem <= cmd.final_elem;
      tag1_r.row        <= IDX_W'(rd_i);
      tag1_r.col        <= IDX_W'(rd_j);
    end
    if (v1_r) begin
      prod_r <= rd_a_r * rd_b_r;
      tag2_r <= tag1_r;
    end
  end

  // accumulate stage
  assign sum      = tag2_r.first ? prod_r : acc_r + prod_r;
  assign res_done = v2_r && tag2_r.last;

  always_ff @(posedge clk) begin
    if (v2_r) begin
      acc_r <= sum;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.load_err) begin
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_value_r <= '0;
      out_last_r  <= 1'b1;
      out_err_r   <= 1'b1;
    end else if (res_done) begin
      out_row_r   <= tag2_r.row;
      out_col_r   <= tag2_r.col;
      out_value_r <= sum;
      out_last_r  <= tag2_r.final_elem;
      out_err_r   <= 1'b0;
    end
  end

  // output register occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_err || res_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign status.res_done = res_done;

  assign out_valid         = out_valid_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_product_value = out_value_r;
  assign out_last_result   = out_last_r;
  assign out_size_error    = out_err_r;

  // a finished sum never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_done |-> (!out_valid_r || out_ready))
    else $error("result overwrites pending output");

  // error result and product result never load together
  a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_err |-> !res_done)
    else $error("error and product loaded together");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r &&
      $stable({out_row_r, out_col_r, out_value_r, out_last_r, out_err_r})))
    else $error("stalled result changed");

endmodule

>>> src/integer_matrix_multiply.sv
`timescale 1ns / 1ps
// integer matrix multiply, C = A x B with 32-bit wrapping sums
// input channel (in_valid/in_ready): one transfer writes an element of A or
//   of B at (row, col), or starts a compute; element writes give no
//   result, and writes outside the store are dropped
// config channel (cfg_valid/cfg_ready): sets rows_a, cols_a, rows_b, cols_b;
//   taken only while idle, sizes are clamped to 1..MAX_DIM
// output channel (out_valid/out_ready): results of a compute in row-major
//   order, the final one flagged by out_last_result; on an inner size
//   mismatch a single result with out_size_error set
// pipeline: results come one at a time from a shared multiply accumulate
//   pipeline (registered store read, multiply, accumulate); the next result
//   is not started until the last one is done, and no input is taken until
//   the final result is in the output reg
// reset: sizes return to 1, the stores keep whatever they held and must be
//   written before use
// stall: a held output register stops the start of the next element until
//   out_ready takes the pending result; an element already started runs on
module integer_matrix_multiply #(
  parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [imm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [imm_pkg::SIZE_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [imm_pkg::OP_W-1:0]            in_operation,
  input  logic [imm_pkg::IDX_W-1:0]           in_row_index,
  input  logic [imm_pkg::IDX_W-1:0]           in_col_index,
  input  logic signed [imm_pkg::DATA_W-1:0]   in_element_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [imm_pkg::IDX_W-1:0]           out_row,
  output logic [imm_pkg::IDX_W-1:0]           out_col,
  output logic signed [imm_pkg::DATA_W-1:0]   out_product_value,
  output logic                                out_last_result,
  output logic                                out_size_error
);
  import imm_pkg::*;

  localparam int IW = $clog2(MAX_DIM);

  cmd_t          cmd;
  stat_t         status;
  logic [IW-1:0] rd_i, rd_j, rd_k;

  // sequencer and size registers
  imm_ctrl #(
    .MAX_DIM(MAX_DIM)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_row_index (in_row_index),
    .in_col_index (in_col_index),
    .status       (status),
    .cmd          (cmd),
    .rd_i         (rd_i),
    .rd_j         (rd_j),
    .rd_k         (rd_k)
  );

  // stores, multiply accumulate pipeline and output register
  imm_dpath #(
    .MAX_DIM(MAX_DIM)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .status            (status),
    .rd_i              (rd_i),
    .rd_j              (rd_j),
    .rd_k              (rd_k),
    .in_row_index      (in_row_index),
    .in_col_index      (in_col_index),
    .in_element_value  (in_element_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_product_value (out_product_value),
    .out_last_result   (out_last_result),
    .out_size_error    (out_size_error)
  );

endmodule
